>>> src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// 3x3 matrix inverse package
// Transaction types shared by the matrix inverse block and its checker.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] word_t;

  typedef struct packed {
    word_t a00;
    word_t a01;
    word_t a02;
    word_t a10;
    word_t a11;
    word_t a12;
    word_t a20;
    word_t a21;
    word_t a22;
  } mi3_in_t;

  typedef struct packed {
    word_t inv00;
    word_t inv01;
    word_t inv02;
    word_t inv10;
    word_t inv11;
    word_t inv12;
    word_t inv20;
    word_t inv21;
    word_t inv22;
    word_t determinant;
    logic  singular;
    logic  saturated;
  } mi3_out_t;

endpackage

>>> src/matrix_inverse_3x3.sv
// Throughput: one transaction per cycle while the pipeline is not stalled; the
// restoring divider resolves one quotient bit per pipeline stage, which sets
// the depth.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// 3x3 matrix inverse
// Adjugate and determinant by cofactor expansion, then nine pipelined
// rounding dividers with saturation.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mi3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mi3_out_t out_data_o
);

  localparam int unsigned W   = DataW;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned AW  = 2 * W + 1;
  localparam int unsigned AMW = 2 * W;
  localparam int unsigned LW  = 2 * W + 1;
  localparam int unsigned TW  = 3 * W + 2;
  localparam int unsigned DTW = 3 * W + 3;
  localparam int unsigned DMW = 3 * W;
  localparam int unsigned NW0 = 2 * W + 2 * F + 2;
  localparam int unsigned NW1 = 4 * W + 1;
  localparam int unsigned RW  = (NW0 > NW1) ? NW0 : NW1;
  localparam int unsigned NS  = W + 10;
  localparam int unsigned DivS = 8;

  localparam logic [DMW:0] DetHalf = (DMW + 1)'(1) << (2 * F - 1);
  localparam logic [DMW:0] LimBig  = (DMW + 1)'(1) << (W - 1);
  localparam logic [W:0]   LimW    = (W + 1)'(1) << (W - 1);

  // Stage control.
  logic [NS-1:0] en;
  logic [NS-1:0] v_d, v_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  // Stage 0: input register.
  word_t a_d [3][3];
  word_t a_q [3][3];

  always_comb begin
    a_d[0][0] = in_data_i.a00;
    a_d[0][1] = in_data_i.a01;
    a_d[0][2] = in_data_i.a02;
    a_d[1][0] = in_data_i.a10;
    a_d[1][1] = in_data_i.a11;
    a_d[1][2] = in_data_i.a12;
    a_d[2][0] = in_data_i.a20;
    a_d[2][1] = in_data_i.a21;
    a_d[2][2] = in_data_i.a22;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q <= a_d;
    end
  end

  // Stages 1 and 2: cofactor products and adjugate.
  logic signed [PW-1:0] pp_d  [3][3];
  logic signed [PW-1:0] pp_q  [3][3];
  logic signed [PW-1:0] pq_d  [3][3];
  logic signed [PW-1:0] pq_q  [3][3];
  logic signed [AW-1:0] adj_d [3][3];
  logic signed [AW-1:0] adj_q [3][3];
  word_t r0_q [1:2][3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int unsigned R1 = (j + 1) % 3;
      localparam int unsigned R2 = (j + 2) % 3;
      localparam int unsigned C1 = (i + 1) % 3;
      localparam int unsigned C2 = (i + 2) % 3;
      assign pp_d[i][j]  = a_q[R1][C1] * a_q[R2][C2];
      assign pq_d[i][j]  = a_q[R1][C2] * a_q[R2][C1];
      assign adj_d[i][j] = {pp_q[i][j][PW-1], pp_q[i][j]} - {pq_q[i][j][PW-1], pq_q[i][j]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pp_q     <= pp_d;
      pq_q     <= pq_d;
      r0_q[1]  <= a_q[0];
    end
    if (en[2]) begin
      adj_q    <= adj_d;
      r0_q[2]  <= r0_q[1];
    end
  end

  // Stage 3: determinant partial products and adjugate magnitudes.
  logic signed [LW-1:0]  lo_d [3];
  logic signed [LW-1:0]  lo_q [3];
  logic signed [LW-1:0]  hi_d [3];
  logic signed [LW-1:0]  hi_q [3];
  logic [AMW-1:0]        am3_d [9];
  logic                  an3_d [9];
  logic [AMW-1:0]        am_q [3:6][9];
  logic                  an_q [3:6][9];

  for (genvar j = 0; j < 3; j++) begin : g_part
    logic signed [W:0] lo_op;
    logic signed [W:0] hi_op;
    assign lo_op   = $signed({1'b0, adj_q[j][0][W-1:0]});
    assign hi_op   = $signed(adj_q[j][0][AW-1:W]);
    assign lo_d[j] = r0_q[2][j] * lo_op;
    assign hi_d[j] = r0_q[2][j] * hi_op;
  end

  for (genvar e = 0; e < 9; e++) begin : g_mag
    logic signed [AW-1:0] adj_neg;
    assign adj_neg  = -adj_q[e/3][e%3];
    assign an3_d[e] = adj_q[e/3][e%3][AW-1];
    assign am3_d[e] = an3_d[e] ? adj_neg[AMW-1:0] : adj_q[e/3][e%3][AMW-1:0];
  end

  // Stages 4 to 6: determinant sum and magnitude.
  logic signed [TW-1:0]  term_d [3];
  logic signed [TW-1:0]  term_q [3];
  logic signed [DTW-1:0] det_d, det_q;
  logic signed [DTW-1:0] det_neg;
  logic [DMW-1:0]        dmag_d, dmag_q;
  logic                  dneg_d, dneg_q;
  logic                  dz6_d, dz6_q;

  for (genvar j = 0; j < 3; j++) begin : g_term
    assign term_d[j] = (TW'(hi_q[j]) <<< W) + TW'(lo_q[j]);
  end

  assign det_d   = DTW'(term_q[0]) + DTW'(term_q[1]) + DTW'(term_q[2]);
  assign det_neg = -det_q;
  assign dneg_d  = det_q[DTW-1];
  assign dmag_d  = dneg_d ? det_neg[DMW-1:0] : det_q[DMW-1:0];
  assign dz6_d   = (det_q == '0);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      am_q[3] <= am3_d;
      an_q[3] <= an3_d;
    end
    if (en[4]) begin
      term_q  <= term_d;
      am_q[4] <= am_q[3];
      an_q[4] <= an_q[3];
    end
    if (en[5]) begin
      det_q   <= det_d;
      am_q[5] <= am_q[4];
      an_q[5] <= an_q[4];
    end
    if (en[6]) begin
      dmag_q  <= dmag_d;
      dneg_q  <= dneg_d;
      dz6_q   <= dz6_d;
      am_q[6] <= am_q[5];
      an_q[6] <= an_q[5];
    end
  end

  // Stage 7: dividend, divisor and rounded determinant.
  logic [RW-1:0]  n_d [9];
  logic [RW-1:0]  n_q [9];
  logic           ng_d [9];
  logic           ng_q [9];
  logic [DMW:0]   dd7_d, dd7_q;
  logic [DMW:0]   dsum, dr, dlim;
  logic           dsat7_d, dsat7_q;
  logic [W-1:0]   dval, dout7_d, dout7_q;
  logic           dz7_q;

  for (genvar e = 0; e < 9; e++) begin : g_num
    assign n_d[e]  = (RW'(am_q[6][e]) << (2 * F + 1)) + RW'(dmag_q);
    assign ng_d[e] = an_q[6][e] ^ dneg_q;
  end

  always_comb begin
    dd7_d   = {dmag_q, 1'b0};
    dsum    = {1'b0, dmag_q} + DetHalf;
    dr      = dsum >> (2 * F);
    dlim    = dneg_q ? LimBig : LimBig - 1'b1;
    dsat7_d = dr > dlim;
    dval    = dsat7_d ? dlim[W-1:0] : dr[W-1:0];
    dout7_d = dneg_q ? -dval : dval;
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      n_q     <= n_d;
      ng_q    <= ng_d;
      dd7_q   <= dd7_d;
      dsat7_q <= dsat7_d;
      dout7_q <= dout7_d;
      dz7_q   <= dz6_q;
    end
  end

  // Stages 8 to 8+W: overflow check and restoring division.
  logic [RW-1:0] rem_q  [0:W][9];
  logic [W-1:0]  qt_q   [0:W][9];
  logic          ovf_q  [0:W][9];
  logic          neg_q  [0:W][9];
  logic [DMW:0]  dd_q   [0:W];
  logic          dz_q   [0:W];
  logic [W-1:0]  dout_q [0:W];
  logic          dsat_q [0:W];

  for (genvar e = 0; e < 9; e++) begin : g_ovf
    logic          ovf_d;
    assign ovf_d = n_q[e] >= (RW'(dd7_q) << W);
    always_ff @(posedge clk_i) begin
      if (en[DivS]) begin
        rem_q[0][e] <= n_q[e];
        qt_q[0][e]  <= '0;
        ovf_q[0][e] <= ovf_d;
        neg_q[0][e] <= ng_q[e];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[DivS]) begin
      dd_q[0]   <= dd7_q;
      dz_q[0]   <= dz7_q;
      dout_q[0] <= dout7_q;
      dsat_q[0] <= dsat7_q;
    end
  end

  for (genvar t = 1; t <= W; t++) begin : g_step
    localparam int unsigned K = W - t;
    logic [RW-1:0] sh;
    assign sh = RW'(dd_q[t-1]) << K;

    for (genvar e = 0; e < 9; e++) begin : g_ent
      logic          ge;
      logic [RW-1:0] rem_d;
      logic [W-1:0]  qt_d;
      always_comb begin
        ge       = rem_q[t-1][e] >= sh;
        rem_d    = ge ? rem_q[t-1][e] - sh : rem_q[t-1][e];
        qt_d     = qt_q[t-1][e];
        qt_d[K]  = ge;
      end
      always_ff @(posedge clk_i) begin
        if (en[DivS+t]) begin
          rem_q[t][e] <= rem_d;
          qt_q[t][e]  <= qt_d;
          ovf_q[t][e] <= ovf_q[t-1][e];
          neg_q[t][e] <= neg_q[t-1][e];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[DivS+t]) begin
        dd_q[t]   <= dd_q[t-1];
        dz_q[t]   <= dz_q[t-1];
        dout_q[t] <= dout_q[t-1];
        dsat_q[t] <= dsat_q[t-1];
      end
    end
  end

  // Final stage: saturation, sign and output register.
  logic [W-1:0] res  [9];
  logic [8:0]   esat;
  mi3_out_t     out_d, out_q;

  for (genvar e = 0; e < 9; e++) begin : g_fin
    logic [W:0]   lim;
    logic [W-1:0] mag;
    always_comb begin
      lim     = neg_q[W][e] ? LimW : LimW - 1'b1;
      esat[e] = ovf_q[W][e] || ({1'b0, qt_q[W][e]} > lim);
      mag     = esat[e] ? lim[W-1:0] : qt_q[W][e];
      res[e]  = dz_q[W] ? '0 : (neg_q[W][e] ? -mag : mag);
    end
  end

  always_comb begin
    out_d.inv00       = res[0];
    out_d.inv01       = res[1];
    out_d.inv02       = res[2];
    out_d.inv10       = res[3];
    out_d.inv11       = res[4];
    out_d.inv12       = res[5];
    out_d.inv20       = res[6];
    out_d.inv21       = res[7];
    out_d.inv22       = res[8];
    out_d.determinant = dz_q[W] ? '0 : dout_q[W];
    out_d.singular    = dz_q[W];
    out_d.saturated   = !dz_q[W] && ((|esat) || dsat_q[W]);
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> src/mi3_chk.sv
// ----------------------------------------------------------------------------
// 3x3 matrix inverse checker
// Port-level assertions on the matrix inverse block, bound to its top level.
// ----------------------------------------------------------------------------
module mi3_chk import mi3_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input mi3_out_t out_data_o
);

  // A held result stays offered until its transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // The input side only stalls when the whole pipeline is full and blocked.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline could advance");

  // A singular result carries zero entries and no saturation.
  a_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.inv00 == '0 && out_data_o.inv01 == '0 && out_data_o.inv02 == '0 &&
      out_data_o.inv10 == '0 && out_data_o.inv11 == '0 && out_data_o.inv12 == '0 &&
      out_data_o.inv20 == '0 && out_data_o.inv21 == '0 && out_data_o.inv22 == '0 &&
      out_data_o.determinant == '0 && !out_data_o.saturated)
    else $error("singular result with nonzero fields");

endmodule

bind matrix_inverse_3x3 mi3_chk u_mi3_chk (.*);
